### design/ppdc_pkg.sv
// ppdc_pkg: shared types and constants for the point-plot display controller.
// Used by ppdc_cfg, ppdc_step and point_plot_display_controller.
// No dependencies.
package ppdc_pkg;

    // Default coordinate register width.
    localparam int unsigned COORD_BITS_DEF = 10;

    // Widths of the fixed fields.
    localparam int unsigned AC_W      = 12;
    localparam int unsigned EN_W      = 6;
    localparam int unsigned PLOT_W    = 10;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned ERASE_W   = 17;
    localparam int unsigned PEND_W    = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 17;

    // Enable register bit positions.
    localparam int unsigned EN_INT   = 0;
    localparam int unsigned EN_CHAN  = 1;
    localparam int unsigned EN_COLOR = 2;
    localparam int unsigned EN_ERASE = 3;
    localparam int unsigned EN_STORE = 4;
    localparam int unsigned EN_WRTHR = 5;

    // Status word: done flag position.
    localparam int unsigned ST_DONE = 11;

    // Pending count saturation value.
    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    // Input kinds.
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_MASK  = 3'd4;

    // Configuration reset values.
    localparam logic [TICK_W-1:0]  RST_SETTLE   = 16'd21;
    localparam logic [TICK_W-1:0]  RST_TO_RED   = 16'd300;
    localparam logic [TICK_W-1:0]  RST_TO_GREEN = 16'd1600;
    localparam logic [ERASE_W-1:0] RST_ERASE    = 17'd50000;
    localparam logic [EN_W-1:0]    RST_EN_MASK  = 6'd3;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_CLR_DONE  = 3'd1,
        OP_SKIP_DONE = 3'd2,
        OP_LOAD_X    = 3'd3,
        OP_LOAD_Y    = 3'd4,
        OP_INTENSIFY = 3'd5,
        OP_LOAD_EN   = 3'd6,
        OP_READ_ST   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        SCR_NONE  = 2'd0,
        SCR_FLOOD = 2'd1,
        SCR_CLEAR = 2'd2
    } t_scr;

    typedef struct packed {
        logic [TICK_W-1:0]  settle;
        logic [TICK_W-1:0]  to_red;
        logic [TICK_W-1:0]  to_green;
        logic [ERASE_W-1:0] erase;
        logic [EN_W-1:0]    en_mask;
    } t_cfg;

    typedef struct packed {
        logic                done;
        logic [EN_W-1:0]     en;
        logic [PEND_W-1:0]   pend;
        logic [TICK_W-1:0]   x_tmr;
        logic [TICK_W-1:0]   y_tmr;
        logic [TICK_W-1:0]   col_tmr;
        logic [ERASE_W-1:0]  ers_tmr;
    } t_state;

    typedef struct packed {
        logic [AC_W-1:0]   ac_out;
        logic              ac_write;
        logic              skip;
        logic              irq;
        logic              plot_valid;
        logic [PLOT_W-1:0] plot_x;
        logic [PLOT_W-1:0] plot_y;
        t_scr              screen_cmd;
        logic              beam_red;
    } t_result;

endpackage

### design/point_plot_display_controller.sv
// point_plot_display_controller: top level of the point-plot display controller.
// Depends on ppdc_pkg, ppdc_cfg, ppdc_timer and ppdc_step.
//
// Point-plot display controller. Each input transfer is either a processor I/O
// command (op 0-7 with the 12-bit accumulator) or a one-microsecond tick, and
// each one gives exactly one result transfer. The block holds the X and Y
// coordinate registers, the enable register, the done flag, four settling timers
// (X, Y, colour change, erase) and a saturating count of running timers. Done is
// set when the last running timer expires, or at once on intensify when nothing
// is pending; irq is the level done AND interrupt enable. Throughput is one
// transfer per clock: the whole step is a single pass of logic from the state
// registers into the result register, and the result appears on the output in
// the cycle after its input transfer. The result register sits between the two
// channels, so a new item is taken in the same cycle that the held result is
// taken; input ready drops only while a result is stalled. Configuration writes
// take effect on the next edge and must only be made while the block is idle.
module point_plot_display_controller #(
    parameter int unsigned COORD_BITS = ppdc_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [ppdc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppdc_pkg::CFG_DAT_W-1:0] i_cfg_data,

    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [2:0]                     i_op,
    input  logic [ppdc_pkg::AC_W-1:0]      i_ac_in,

    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ppdc_pkg::AC_W-1:0]      o_ac_out,
    output logic                           o_ac_write,
    output logic                           o_skip,
    output logic                           o_irq,
    output logic                           o_plot_valid,
    output logic [ppdc_pkg::PLOT_W-1:0]    o_plot_x,
    output logic [ppdc_pkg::PLOT_W-1:0]    o_plot_y,
    output logic [1:0]                     o_screen_cmd,
    output logic                           o_beam_red
);

    ppdc_pkg::t_cfg    cfg;
    ppdc_pkg::t_state  r_state, n_state;
    ppdc_pkg::t_result r_res, n_res;
    logic [COORD_BITS-1:0] r_x, n_x;
    logic [COORD_BITS-1:0] r_y, n_y;
    logic              r_out_valid;
    logic              in_xfer;

    ppdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ppdc_step #(.COORD_BITS(COORD_BITS)) u_step (
        .i_kind  (i_kind),
        .i_op    (i_op),
        .i_ac    (i_ac_in),
        .i_cfg   (cfg),
        .i_state (r_state),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_state (n_state),
        .o_x     (n_x),
        .o_y     (n_y),
        .o_res   (n_res)
    );

    // take a new item whenever the result register is empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // architectural state: moves only on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_x     <= '0;
            r_y     <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ac_out     = r_res.ac_out;
    assign o_ac_write   = r_res.ac_write;
    assign o_skip       = r_res.skip;
    assign o_irq        = r_res.irq;
    assign o_plot_valid = r_res.plot_valid;
    assign o_plot_x     = r_res.plot_x;
    assign o_plot_y     = r_res.plot_y;
    assign o_screen_cmd = r_res.screen_cmd;
    assign o_beam_red   = r_res.beam_red;

    // irq in the result tracks the state written with it
    a_irq_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_res.irq == (r_state.done && r_state.en[ppdc_pkg::EN_INT])))
        else $error("irq does not match done and interrupt enable");

    // beam colour in the result tracks the enable register written with it
    a_beam_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_res.beam_red == r_state.en[ppdc_pkg::EN_COLOR]))
        else $error("beam colour does not match enable register");

    // a plot result never carries an accumulator write or a screen command
    a_plot_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.plot_valid) |->
            (!r_res.ac_write && (r_res.screen_cmd == ppdc_pkg::SCR_NONE)))
        else $error("plot result mixed with other actions");

    // a stalled result blocks the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result stalled");

endmodule

### design/ppdc_cfg.sv
// ppdc_cfg: configuration register file with write-only port.
// Depends on ppdc_pkg.
module ppdc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ppdc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppdc_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output ppdc_pkg::t_cfg                   o_cfg
);

    ppdc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle   <= ppdc_pkg::RST_SETTLE;
            r_cfg.to_red   <= ppdc_pkg::RST_TO_RED;
            r_cfg.to_green <= ppdc_pkg::RST_TO_GREEN;
            r_cfg.erase    <= ppdc_pkg::RST_ERASE;
            r_cfg.en_mask  <= ppdc_pkg::RST_EN_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppdc_pkg::CFG_SETTLE:   r_cfg.settle   <= i_cfg_data[ppdc_pkg::TICK_W-1:0];
                ppdc_pkg::CFG_TO_RED:   r_cfg.to_red   <= i_cfg_data[ppdc_pkg::TICK_W-1:0];
                ppdc_pkg::CFG_TO_GREEN: r_cfg.to_green <= i_cfg_data[ppdc_pkg::TICK_W-1:0];
                ppdc_pkg::CFG_ERASE:    r_cfg.erase    <= i_cfg_data[ppdc_pkg::ERASE_W-1:0];
                ppdc_pkg::CFG_EN_MASK:  r_cfg.en_mask  <= i_cfg_data[ppdc_pkg::EN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/ppdc_timer.sv
// ppdc_timer: next-value logic for one settling timer (load, count down, expiry).
// No package dependency; width set by parameter.
module ppdc_timer #(
    parameter int unsigned W = 16
) (
    input  logic [W-1:0] i_cnt,
    input  logic         i_tick,
    input  logic         i_start,
    input  logic [W-1:0] i_load,
    output logic [W-1:0] o_next,
    output logic         o_idle,
    output logic         o_expire
);

    localparam logic [W-1:0] ONE = W'(1);

    assign o_idle = (i_cnt == '0);

    always_comb begin
        o_next   = i_cnt;
        o_expire = 1'b0;
        if (i_start) begin
            // zero delay: timer stays idle and expires straight away
            o_next   = i_load;
            o_expire = (i_load == '0);
        end else if (i_tick && !o_idle) begin
            o_next   = i_cnt - ONE;
            o_expire = (i_cnt == ONE);
        end
    end

endmodule

### design/ppdc_step.sv
// ppdc_step: combinational step logic, one command or tick against the current state.
// Depends on ppdc_pkg and ppdc_timer.
module ppdc_step #(
    parameter int unsigned COORD_BITS = ppdc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_kind,
    input  logic [2:0]                   i_op,
    input  logic [ppdc_pkg::AC_W-1:0]    i_ac,
    input  ppdc_pkg::t_cfg               i_cfg,
    input  ppdc_pkg::t_state             i_state,
    input  logic [COORD_BITS-1:0]        i_x,
    input  logic [COORD_BITS-1:0]        i_y,
    output ppdc_pkg::t_state             o_state,
    output logic [COORD_BITS-1:0]        o_x,
    output logic [COORD_BITS-1:0]        o_y,
    output ppdc_pkg::t_result            o_res
);

    localparam logic [COORD_BITS-1:0] COORD_TOP = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam int unsigned WIDE_W = COORD_BITS + ppdc_pkg::PLOT_W;

    typedef struct packed {
        logic [ppdc_pkg::PEND_W-1:0] cnt;
        logic                        done;
    } t_pend;

    function automatic t_pend f_expire(t_pend p);
        t_pend q;
        q = p;
        if (q.cnt != '0) q.cnt = q.cnt - 3'd1;
        if (q.cnt == '0) q.done = 1'b1;
        return q;
    endfunction

    function automatic t_pend f_up(t_pend p);
        t_pend q;
        q = p;
        if (q.cnt != ppdc_pkg::PEND_MAX) q.cnt = q.cnt + 3'd1;
        return q;
    endfunction

    function automatic t_pend f_start(t_pend p, logic idle, logic zero);
        t_pend q;
        q = p;
        if (idle) q = f_up(q);
        if (zero) q = f_expire(q);
        return q;
    endfunction

    ppdc_pkg::t_op             op;
    logic                      is_cmd;
    logic                      is_tick;
    logic [ppdc_pkg::EN_W-1:0] en_ld;
    logic                      col_chg;
    logic                      x_start, y_start, c_start, e_start;
    logic [ppdc_pkg::TICK_W-1:0] col_load;
    logic [ppdc_pkg::TICK_W-1:0] x_nxt, y_nxt, c_nxt;
    logic [ppdc_pkg::ERASE_W-1:0] e_nxt;
    logic                      x_idle, y_idle, c_idle, e_idle;
    logic                      x_exp, y_exp, c_exp, e_exp;
    logic [COORD_BITS-1:0]     x_flip, y_flip;
    logic [WIDE_W-1:0]         x_wide, y_wide;
    t_pend                     p0, p1;

    assign op      = ppdc_pkg::t_op'(i_op);
    assign is_cmd  = (i_kind == ppdc_pkg::KIND_CMD);
    assign is_tick = (i_kind == ppdc_pkg::KIND_TICK);

    assign en_ld   = i_state.en | (i_ac[ppdc_pkg::EN_W-1:0] & i_cfg.en_mask);
    assign col_chg = en_ld[ppdc_pkg::EN_COLOR] ^ i_state.en[ppdc_pkg::EN_COLOR];

    assign x_start = is_cmd && (op == ppdc_pkg::OP_LOAD_X);
    assign y_start = is_cmd && (op == ppdc_pkg::OP_LOAD_Y);
    assign c_start = is_cmd && (op == ppdc_pkg::OP_LOAD_EN) && col_chg;
    assign e_start = is_cmd && (op == ppdc_pkg::OP_LOAD_EN) && en_ld[ppdc_pkg::EN_ERASE];
    assign col_load = en_ld[ppdc_pkg::EN_COLOR] ? i_cfg.to_red : i_cfg.to_green;

    ppdc_timer #(.W(ppdc_pkg::TICK_W)) u_x_tmr (
        .i_cnt (i_state.x_tmr), .i_tick (is_tick), .i_start (x_start),
        .i_load (i_cfg.settle), .o_next (x_nxt), .o_idle (x_idle), .o_expire (x_exp)
    );

    ppdc_timer #(.W(ppdc_pkg::TICK_W)) u_y_tmr (
        .i_cnt (i_state.y_tmr), .i_tick (is_tick), .i_start (y_start),
        .i_load (i_cfg.settle), .o_next (y_nxt), .o_idle (y_idle), .o_expire (y_exp)
    );

    ppdc_timer #(.W(ppdc_pkg::TICK_W)) u_col_tmr (
        .i_cnt (i_state.col_tmr), .i_tick (is_tick), .i_start (c_start),
        .i_load (col_load), .o_next (c_nxt), .o_idle (c_idle), .o_expire (c_exp)
    );

    ppdc_timer #(.W(ppdc_pkg::ERASE_W)) u_ers_tmr (
        .i_cnt (i_state.ers_tmr), .i_tick (is_tick), .i_start (e_start),
        .i_load (i_cfg.erase), .o_next (e_nxt), .o_idle (e_idle), .o_expire (e_exp)
    );

    // coordinates shifted to a lower-left origin, then cut or padded to the plot width
    assign x_flip = i_x ^ COORD_TOP;
    assign y_flip = i_y ^ COORD_TOP;
    assign x_wide = {{ppdc_pkg::PLOT_W{1'b0}}, x_flip};
    assign y_wide = {{ppdc_pkg::PLOT_W{1'b0}}, y_flip};

    always_comb begin
        o_state         = i_state;
        o_state.x_tmr   = x_nxt;
        o_state.y_tmr   = y_nxt;
        o_state.col_tmr = c_nxt;
        o_state.ers_tmr = e_nxt;
        o_x             = i_x;
        o_y             = i_y;
        o_res           = '0;
        o_res.screen_cmd = ppdc_pkg::SCR_NONE;
        p0.cnt  = i_state.pend;
        p0.done = i_state.done;
        p1      = p0;

        if (is_tick) begin
            // expiries taken in order X, Y, colour, erase
            if (x_exp) p1 = f_expire(p1);
            if (y_exp) p1 = f_expire(p1);
            if (c_exp) p1 = f_expire(p1);
            if (e_exp) p1 = f_expire(p1);
            if (e_exp) o_res.screen_cmd = ppdc_pkg::SCR_CLEAR;
        end else begin
            case (op)
                ppdc_pkg::OP_CLEAR: begin
                    o_state.en = '0;
                    p1.done    = 1'b0;
                end
                ppdc_pkg::OP_CLR_DONE: begin
                    p1.done = 1'b0;
                end
                ppdc_pkg::OP_SKIP_DONE: begin
                    o_res.skip = i_state.done;
                end
                ppdc_pkg::OP_LOAD_X: begin
                    p1.done = 1'b0;
                    o_x     = i_ac[COORD_BITS-1:0];
                    p1      = f_start(p1, x_idle, x_exp);
                end
                ppdc_pkg::OP_LOAD_Y: begin
                    p1.done = 1'b0;
                    o_y     = i_ac[COORD_BITS-1:0];
                    p1      = f_start(p1, y_idle, y_exp);
                end
                ppdc_pkg::OP_INTENSIFY: begin
                    p1.done          = 1'b0;
                    o_res.plot_valid = 1'b1;
                    o_res.plot_x     = x_wide[ppdc_pkg::PLOT_W-1:0];
                    o_res.plot_y     = y_wide[ppdc_pkg::PLOT_W-1:0];
                    p1               = f_expire(f_up(p1));
                end
                ppdc_pkg::OP_LOAD_EN: begin
                    o_state.en     = en_ld;
                    o_res.ac_write = 1'b1;
                    if (c_start) p1 = f_start(p1, c_idle, c_exp);
                    if (e_start) begin
                        p1 = f_start(p1, e_idle, e_exp);
                        o_res.screen_cmd = e_exp ? ppdc_pkg::SCR_CLEAR : ppdc_pkg::SCR_FLOOD;
                    end
                end
                default: begin
                    o_res.ac_write = 1'b1;
                    o_res.ac_out   = {i_state.done,
                                      {(ppdc_pkg::ST_DONE - ppdc_pkg::EN_W){1'b0}},
                                      i_state.en};
                end
            endcase
        end

        o_state.pend  = p1.cnt;
        o_state.done  = p1.done;
        o_res.irq      = p1.done & o_state.en[ppdc_pkg::EN_INT];
        o_res.beam_red = o_state.en[ppdc_pkg::EN_COLOR];
    end

endmodule
